[rtl/brkm_pkg.sv]
// ----------------------------------------------------------------------------
// brkm_pkg
// Shared types and constants of the bucketed reverse key map.
// ----------------------------------------------------------------------------
package brkm_pkg;

    localparam int WAYS        = 4;
    localparam int BUCKET_BITS = 8;
    localparam int NUM_BUCKETS = 1 << BUCKET_BITS;
    localparam int SYM_W       = 32;
    localparam int CODE_W      = 8;
    localparam int FILL_W      = $clog2(WAYS + 1);

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_LOOKUP = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_EVAL
    } t_state;

    typedef struct packed {
        logic              mode;
        logic [SYM_W-1:0]  symbol;
        logic [CODE_W-1:0] new_code;
    } t_req;

    typedef struct packed {
        logic [SYM_W-1:0] answer;
        logic             hit;
        logic             overflow;
    } t_rsp;

    typedef struct packed {
        logic [FILL_W-1:0]            fill;
        logic [WAYS-1:0][CODE_W-1:0]  code;
        logic [WAYS-1:0][SYM_W-1:0]   sym;
    } t_row;

    localparam int ROW_W = $bits(t_row);

endpackage

[rtl/brkm_req_if.sv]
// ----------------------------------------------------------------------------
// brkm_req_if
// Request channel: insert or lookup of one key symbol.
// ----------------------------------------------------------------------------
interface brkm_req_if;
    import brkm_pkg::*;

    logic              valid;
    logic              ready;
    logic              mode;
    logic [SYM_W-1:0]  symbol;
    logic [CODE_W-1:0] new_code;

    modport source (output valid, output mode, output symbol, output new_code, input ready);
    modport sink   (input valid, input mode, input symbol, input new_code, output ready);
endinterface

[rtl/brkm_rsp_if.sv]
// ----------------------------------------------------------------------------
// brkm_rsp_if
// Response channel: answer with hit and overflow flags.
// ----------------------------------------------------------------------------
interface brkm_rsp_if;
    import brkm_pkg::*;

    logic             valid;
    logic             ready;
    logic [SYM_W-1:0] answer;
    logic             hit;
    logic             overflow;

    modport source (output valid, output answer, output hit, output overflow, input ready);
    modport sink   (input valid, input answer, input hit, input overflow, output ready);
endinterface

[rtl/bucketed_reverse_key_map.sv]
// ----------------------------------------------------------------------------
// bucketed_reverse_key_map
// Set-associative reverse map from key symbols to key codes, one row per
// bucket holding the fill count, codes and symbols of all ways.
// ----------------------------------------------------------------------------
// channel  dir  payload                       handshake
// i_req    in   mode, symbol, new_code        valid/ready
// o_rsp    out  answer, hit, overflow         valid/ready
//
// The row RAM is read in the accept cycle; the row is compared and
// written back in the next, when no new request is taken.
// Reset clears the per-bucket valid bits at once; no clearing pass.
// A waiting response holds the request side until it is taken; a new
// request may enter in the cycle the response drains.
// ----------------------------------------------------------------------------
module bucketed_reverse_key_map (
    input  logic        i_clk,
    input  logic        i_rst_n,
    brkm_req_if.sink    i_req,
    brkm_rsp_if.source  o_rsp
);
    import brkm_pkg::*;

    t_state                  r_state, n_state;
    t_req                    r_req;
    t_rsp                    r_rsp, n_rsp;
    logic                    r_out_valid;
    logic [NUM_BUCKETS-1:0]  r_row_valid;

    logic                    req_accept;
    logic                    ram_we;
    logic [ROW_W-1:0]        ram_rdata;
    t_row                    rd_row, wr_row;
    logic [BUCKET_BITS-1:0]  bucket;
    logic [FILL_W-1:0]       fill;
    logic                    lk_hit;
    logic [CODE_W-1:0]       lk_code;

    assign bucket     = r_req.symbol[BUCKET_BITS-1:0];
    assign req_accept = i_req.valid && i_req.ready;
    assign rd_row     = t_row'(ram_rdata);
    assign fill       = r_row_valid[bucket] ? rd_row.fill : '0;

    brkm_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_BUCKETS)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (bucket),
        .i_wdata (wr_row),
        .i_re    (req_accept),
        .i_raddr (i_req.symbol[BUCKET_BITS-1:0]),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        lk_hit  = 1'b0;
        lk_code = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (FILL_W'(w) < fill && rd_row.sym[w] == r_req.symbol) begin
                lk_hit  = 1'b1;
                lk_code = rd_row.code[w];
            end
        end
    end

    always_comb begin
        wr_row      = rd_row;
        wr_row.fill = fill + FILL_W'(1);
        for (int w = 0; w < WAYS; w++) begin
            if (FILL_W'(w) == fill) begin
                wr_row.sym[w]  = r_req.symbol;
                wr_row.code[w] = r_req.new_code;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        i_req.ready = 1'b0;
        ram_we      = 1'b0;
        n_rsp       = '0;
        unique case (r_state)
            ST_IDLE: begin
                i_req.ready = !r_out_valid || o_rsp.ready;
                if (req_accept) begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                n_state = ST_IDLE;
                if (r_req.mode == MODE_LOOKUP) begin
                    n_rsp.hit    = lk_hit;
                    n_rsp.answer = lk_hit ? {{(SYM_W-CODE_W){1'b0}}, lk_code}
                                          : r_req.symbol;
                end else if (r_req.symbol != '0) begin
                    if (fill >= FILL_W'(WAYS)) begin
                        n_rsp.overflow = 1'b1;
                    end else begin
                        ram_we = 1'b1;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (req_accept) begin
            r_req.mode     <= i_req.mode;
            r_req.symbol   <= i_req.symbol;
            r_req.new_code <= i_req.new_code;
        end
        if (r_state == ST_EVAL) begin
            r_rsp <= n_rsp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_row_valid <= '0;
        end else begin
            if (r_state == ST_EVAL) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            if (ram_we) begin
                r_row_valid[bucket] <= 1'b1;
            end
        end
    end

    assign o_rsp.valid    = r_out_valid;
    assign o_rsp.answer   = r_rsp.answer;
    assign o_rsp.hit      = r_rsp.hit;
    assign o_rsp.overflow = r_rsp.overflow;

    a_eval_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_EVAL |-> $past(req_accept))
        else $error("evaluation without an accepted request");

    a_out_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_EVAL |-> !r_out_valid)
        else $error("response register busy at evaluation");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_rsp.hit && r_rsp.overflow))
        else $error("hit and overflow both set");

    a_hit_is_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_rsp.hit |-> r_rsp.answer[SYM_W-1:CODE_W] == '0)
        else $error("hit answer wider than a code");

    a_write_marks_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |=> r_row_valid[$past(bucket)])
        else $error("written bucket not marked valid");
endmodule

[rtl/brkm_ram.sv]
// ----------------------------------------------------------------------------
// brkm_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module brkm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

[dv/bucketed_reverse_key_map_tb.sv]
// ----------------------------------------------------------------------------
// bucketed_reverse_key_map_tb
// Self-checking bench for the bucketed reverse key map. Inserts and lookups
// go in over the request channel while a local copy of the bucket table
// works out each answer; every response is compared field by field, in
// order, with the answer worked out for its request. Directed requests hit
// empty, full and duplicate buckets and zero symbols. Random traffic then
// favors a few hot buckets and symbols already stored, under random idling,
// a long response stall and full-rate streaming.
// ----------------------------------------------------------------------------
module bucketed_reverse_key_map_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import brkm_pkg::*;

    localparam int IDLE_LIMIT = 4000;
    localparam int DRAIN_WAIT = 8;
    localparam int HOLD_LEN   = 300;

    logic i_clk = 1'b0;
    logic i_rst_n;

    brkm_req_if req_if ();
    brkm_rsp_if rsp_if ();

    bucketed_reverse_key_map dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always #5 i_clk = ~i_clk;

    int                mismatch_count = 0;
    bit                req_idle_en    = 1'b1;
    bit                rsp_idle_en    = 1'b1;
    int                hold_request   = 0;
    int                idle_cycles    = 0;
    t_rsp              pending_answers[$];
    logic [SYM_W-1:0]  stored_symbols[$];
    int                table_fill[NUM_BUCKETS];
    logic [SYM_W-1:0]  table_sym[NUM_BUCKETS][WAYS];
    logic [CODE_W-1:0] table_code[NUM_BUCKETS][WAYS];

    initial begin
        foreach (table_fill[b]) table_fill[b] = 0;
    end

    function automatic t_rsp predict_key_map(logic mode, logic [SYM_W-1:0] sym,
                                             logic [CODE_W-1:0] code);
        t_rsp r;
        int   b;
        int   n;
        r = '0;
        b = sym[BUCKET_BITS-1:0];
        n = table_fill[b];
        if (mode == MODE_INSERT) begin
            if (sym != '0) begin
                if (n >= WAYS) begin
                    r.overflow = 1'b1;
                end else begin
                    table_sym[b][n]  = sym;
                    table_code[b][n] = code;
                    table_fill[b]    = n + 1;
                    stored_symbols.push_back(sym);
                end
            end
        end else begin
            r.answer = sym;
            for (int w = n - 1; w >= 0; w--) begin
                if (table_sym[b][w] == sym) begin
                    r.answer = {{(SYM_W-CODE_W){1'b0}}, table_code[b][w]};
                    r.hit    = 1'b1;
                end
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [SYM_W-1:0] got,
                                   logic [SYM_W-1:0] want);
        $display("[%0t] mismatch %s: got %h want %h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    task automatic send_request(logic mode, logic [SYM_W-1:0] sym, logic [CODE_W-1:0] code);
        int gap;
        gap = (req_idle_en && $urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 0;
        if (gap > 0) begin
            req_if.valid    <= 1'b0;
            req_if.mode     <= 1'($urandom_range(0, 1));
            req_if.symbol   <= $urandom;
            req_if.new_code <= CODE_W'($urandom_range(0, 255));
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid    <= 1'b1;
        req_if.mode     <= mode;
        req_if.symbol   <= sym;
        req_if.new_code <= code;
        do @(posedge i_clk); while (!req_if.ready);
        pending_answers.push_back(predict_key_map(mode, sym, code));
    endtask

    task automatic wait_for_answers();
        req_if.valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    function automatic logic [SYM_W-1:0] pick_symbol();
        logic [SYM_W-1:0] s;
        int               sel;
        sel = $urandom_range(0, 99);
        s   = $urandom;
        if (sel < 45 && stored_symbols.size() > 0) begin
            s = stored_symbols[$urandom_range(0, stored_symbols.size() - 1)];
        end else if (sel < 80) begin
            s[7:0] = {4'hC, 4'($urandom_range(0, 15))};
        end else if (sel < 83) begin
            s = '0;
        end
        return s;
    endfunction

    task automatic send_random_request();
        send_request($urandom_range(0, 1) ? MODE_LOOKUP : MODE_INSERT, pick_symbol(),
                     CODE_W'($urandom_range(0, 255)));
    endtask

    task automatic test_directed();
        send_request(MODE_LOOKUP, 32'h1234_5678, 8'h00);
        send_request(MODE_LOOKUP, 32'h0000_0000, 8'hFF);
        send_request(MODE_INSERT, 32'h0000_0000, 8'hAB);
        send_request(MODE_LOOKUP, 32'h0000_0000, 8'h00);
        send_request(MODE_INSERT, 32'hFFFF_FFFF, 8'hFF);
        send_request(MODE_LOOKUP, 32'hFFFF_FFFF, 8'h00);
        send_request(MODE_INSERT, 32'h0000_0100, 8'h00);
        send_request(MODE_LOOKUP, 32'h0000_0100, 8'h55);
        send_request(MODE_LOOKUP, 32'h0000_0200, 8'h00);
        send_request(MODE_INSERT, 32'hA5A5_A57A, 8'h11);
        send_request(MODE_INSERT, 32'h0000_017A, 8'h22);
        send_request(MODE_INSERT, 32'hA5A5_A57A, 8'h33);
        send_request(MODE_INSERT, 32'h8000_007A, 8'h80);
        send_request(MODE_INSERT, 32'h5A5A_5A7A, 8'h44);
        send_request(MODE_LOOKUP, 32'hA5A5_A57A, 8'h00);
        send_request(MODE_LOOKUP, 32'h8000_007A, 8'h00);
        send_request(MODE_LOOKUP, 32'h5A5A_5A7A, 8'h00);
        send_request(MODE_LOOKUP, 32'h7FFF_FF7A, 8'h00);
        send_request(MODE_INSERT, 32'h0001_0000, 8'h01);
        send_request(MODE_INSERT, 32'h8000_0000, 8'hFE);
        send_request(MODE_INSERT, 32'h0000_FF00, 8'h7F);
        send_request(MODE_INSERT, 32'h0000_0000, 8'hC3);
        send_request(MODE_INSERT, 32'h0000_0F00, 8'h99);
        send_request(MODE_LOOKUP, 32'h8000_0000, 8'h00);
        wait_for_answers();
    endtask

    task automatic test_random_mix(int count);
        repeat (count) send_random_request();
        wait_for_answers();
    endtask

    task automatic test_stall_fill();
        req_idle_en  = 1'b0;
        hold_request = HOLD_LEN;
        repeat (12) send_random_request();
        wait_for_answers();
        req_idle_en = 1'b1;
    endtask

    task automatic test_pause_drain();
        repeat (4) begin
            repeat (25) send_random_request();
            wait_for_answers();
        end
    endtask

    task automatic test_full_rate(int count);
        req_idle_en = 1'b0;
        rsp_idle_en = 1'b0;
        repeat (count) send_random_request();
    endtask

    initial begin : rsp_sink
        int stall_left;
        int run_left;
        stall_left = 0;
        run_left   = 0;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request > 0) begin
                stall_left   = hold_request;
                hold_request = 0;
                run_left     = 0;
            end else if (stall_left == 0 && run_left == 0) begin
                if (rsp_idle_en && $urandom_range(0, 2) == 0)
                    stall_left = $urandom_range(1, 10);
                else
                    run_left = $urandom_range(1, 16);
            end
            if (stall_left > 0) begin
                rsp_if.ready <= 1'b0;
                stall_left--;
            end else begin
                rsp_if.ready <= 1'b1;
                if (run_left > 0) run_left--;
            end
        end
    end

    always @(posedge i_clk) begin : check_rsp
        t_rsp want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (pending_answers.size() == 0) begin
                report_mismatch("response with nothing pending", rsp_if.answer, '0);
            end else begin
                want = pending_answers.pop_front();
                if (rsp_if.answer !== want.answer)
                    report_mismatch("answer", rsp_if.answer, want.answer);
                if (rsp_if.hit !== want.hit)
                    report_mismatch("hit", 32'(rsp_if.hit), 32'(want.hit));
                if (rsp_if.overflow !== want.overflow)
                    report_mismatch("overflow", 32'(rsp_if.overflow), 32'(want.overflow));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: %0d cycles without a handshake", IDLE_LIMIT);
                $display("status: fail");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n         <= 1'b0;
        req_if.valid    <= 1'b0;
        req_if.mode     <= MODE_INSERT;
        req_if.symbol   <= '0;
        req_if.new_code <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_mix(580);
        test_stall_fill();
        test_pause_drain();
        test_full_rate(430);
        wait_for_answers();
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
